>>> rtl/core/irim_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package irim_pkg;

	// Fixed field widths
	localparam int POS_W      = 7;
	localparam int PIX_W      = 32;
	localparam int COEF_W     = 16;
	localparam int DIM_W      = 8;
	localparam int FRAC_W     = 14;
	localparam int CFG_DATA_W = 16;

	// Register reset values
	localparam logic signed [COEF_W-1:0] COS_RST    = 16'sd16384;
	localparam logic signed [COEF_W-1:0] SIN_RST    = 16'sd0;
	localparam logic [DIM_W-1:0]         WIDTH_RST  = 8'd128;
	localparam logic [DIM_W-1:0]         HEIGHT_RST = 8'd128;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		REG_COS    = 2'd0,
		REG_SIN    = 2'd1,
		REG_WIDTH  = 2'd2,
		REG_HEIGHT = 2'd3
	} cfg_reg_t;

endpackage

`default_nettype wire

>>> rtl/core/irim_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface irim_in_if import irim_pkg::*; ();
	logic              valid;
	logic              ready;
	op_t               op;
	logic [POS_W-1:0]  pos_x;
	logic [POS_W-1:0]  pos_y;
	logic [PIX_W-1:0]  pixel_in;

	modport source (output valid, op, pos_x, pos_y, pixel_in, input ready);
	modport sink   (input valid, op, pos_x, pos_y, pixel_in, output ready);
endinterface

`default_nettype wire

>>> rtl/core/irim_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface irim_out_if import irim_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              inside_res;
	logic [PIX_W-1:0]  pixel_out;

	modport source (output valid, inside_res, pixel_out, input ready);
	modport sink   (input valid, inside_res, pixel_out, output ready);
endinterface

`default_nettype wire

>>> rtl/core/irim_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface irim_cfg_if import irim_pkg::*; ();
	logic                   valid;
	logic                   ready;
	cfg_reg_t               index;
	logic [CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/image_rotate_inverse_map.sv
`timescale 1ns / 1ps
`default_nettype none

// Image rotation about the center, inverse mapped, sampled at truncated coordinates.
// item:   input transactions. A load (op = OP_LOAD) writes pixel_in into the source
//         store at (pos_x, pos_y) and yields no result. A query (op = OP_QUERY)
//         rotates the destination position back into the source image.
// result: one transaction per query: inside_res and the sampled pixel_out
//         (zero when the point falls outside the source image).
// cfg:    register writes (cosine, sine in Q2.14, width, height), always ready;
//         write only while no query is in flight.
// Path:   input register, product register, result register with the store read.
// Throughput: one transaction per cycle unless the result stalls, loads and
//         queries mixed freely. The store has a single port, shared in order by
//         load writes and query reads at the same stage, so a load is always seen
//         by every later query.
// Stall: when result.ready is low the result register holds; the stages behind it
//         keep filling until all three are occupied, then item.ready drops.
//         Loads drain past a stalled result since they produce nothing.
// Reset: arst_n clears the stage valids and sets the registers to cos 1.0, sin 0,
//         128 x 128. The source store is not cleared: load every pixel first.
module image_rotate_inverse_map import irim_pkg::*; #(
	parameter int MAX_DIM = 128
) (
	input  wire              clk,
	input  wire              arst_n,
	irim_in_if.sink          item,
	irim_out_if.source       result,
	irim_cfg_if.sink         cfg
);

	localparam int DX_W      = DIM_W + 1;
	localparam int PROD_W    = DX_W + COEF_W;
	localparam int SUM_W     = PROD_W + 1;
	localparam int TQ_W      = SUM_W - FRAC_W;
	localparam int RX_W      = TQ_W + 1;
	localparam int AW        = $clog2(MAX_DIM);
	localparam int MEM_DEPTH = 1 << (2 * AW);

	// Configuration registers
	logic signed [COEF_W-1:0] cos_q;
	logic signed [COEF_W-1:0] sin_q;
	logic [DIM_W-1:0]         width_q;
	logic [DIM_W-1:0]         height_q;

	// Stage 1: accepted transaction
	logic              v_s1;
	op_t               op_s1;
	logic [POS_W-1:0]  x_s1;
	logic [POS_W-1:0]  y_s1;
	logic [PIX_W-1:0]  pix_s1;

	// Stage 2: products and clamped sizes
	logic                     v_s2;
	op_t                      op_s2;
	logic [POS_W-1:0]         x_s2;
	logic [POS_W-1:0]         y_s2;
	logic [PIX_W-1:0]         pix_s2;
	logic signed [PROD_W-1:0] pcx_s2;
	logic signed [PROD_W-1:0] psx_s2;
	logic signed [PROD_W-1:0] pcy_s2;
	logic signed [PROD_W-1:0] psy_s2;
	logic [DIM_W-1:0]         w_s2;
	logic [DIM_W-1:0]         h_s2;
	logic [DIM_W-1:0]         hw_s2;
	logic [DIM_W-1:0]         hh_s2;

	// Stage 3: result register, read data straight from the store
	logic              v_s3;
	logic              inside_s3;
	logic [PIX_W-1:0]  rd_s3;

	logic [PIX_W-1:0]  mem [MEM_DEPTH];

	// Handshake
	logic s3_free, s2_leave, s2_free, s1_leave, accept;

	// Stage 1 -> 2 logic
	logic [DIM_W-1:0]         w_eff, h_eff, hw, hh;
	logic signed [DX_W-1:0]   dx, dy;
	logic signed [PROD_W-1:0] pcx, psx, pcy, psy;

	// Stage 2 -> 3 logic
	logic signed [SUM_W-1:0]  sx, sy, rnd_x, rnd_y, sxa, sya;
	logic signed [TQ_W-1:0]   tqx, tqy;
	logic signed [RX_W-1:0]   rx, ry;
	logic                     in_x, in_y, in_img;
	logic                     load_ok, mem_wr, rd_en;
	logic [2*AW-1:0]          mem_addr;

	// ---------------------------------------------------------------------
	// Configuration: always ready; the user, unchecked by the block, keeps it written between transactions only
	// ---------------------------------------------------------------------
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_q    <= COS_RST;
			sin_q    <= SIN_RST;
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_COS:    cos_q    <= $signed(cfg.data);
				REG_SIN:    sin_q    <= $signed(cfg.data);
				REG_WIDTH:  width_q  <= cfg.data[DIM_W-1:0];
				REG_HEIGHT: height_q <= cfg.data[DIM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// Flow control: a stage takes a new transaction when it is empty or its
	// occupant moves on. Loads leave stage 2 unconditionally (they write the
	// store and vanish), queries need the result register.
	// ---------------------------------------------------------------------
	assign s3_free    = !v_s3 || result.ready;
	assign s2_leave   = v_s2 && (op_s2 == OP_LOAD || s3_free);
	assign s2_free    = !v_s2 || s2_leave;
	assign s1_leave   = v_s1 && s2_free;
	assign item.ready = !v_s1 || s1_leave;
	assign accept     = item.valid && item.ready;

	// ---------------------------------------------------------------------
	// Stage 1: register the transaction
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (item.ready) begin
			v_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1  <= item.op;
			x_s1   <= item.pos_x;
			y_s1   <= item.pos_y;
			pix_s1 <= item.pixel_in;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 1 -> 2: clamp sizes, center offsets, four Q11.14 products
	// ---------------------------------------------------------------------
	always_comb begin
		w_eff = (32'(width_q) > MAX_DIM) ? DIM_W'(MAX_DIM) : width_q;
		h_eff = (32'(height_q) > MAX_DIM) ? DIM_W'(MAX_DIM) : height_q;
		hw    = w_eff >> 1;
		hh    = h_eff >> 1;
		dx    = $signed(DX_W'(x_s1)) - $signed(DX_W'(hw));
		dy    = $signed(DX_W'(y_s1)) - $signed(DX_W'(hh));
		pcx   = PROD_W'(dx) * PROD_W'(cos_q);
		psx   = PROD_W'(dx) * PROD_W'(sin_q);
		pcy   = PROD_W'(dy) * PROD_W'(cos_q);
		psy   = PROD_W'(dy) * PROD_W'(sin_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_free) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_leave) begin
			op_s2  <= op_s1;
			x_s2   <= x_s1;
			y_s2   <= y_s1;
			pix_s2 <= pix_s1;
			pcx_s2 <= pcx;
			psx_s2 <= psx;
			pcy_s2 <= pcy;
			psy_s2 <= psy;
			w_s2   <= w_eff;
			h_s2   <= h_eff;
			hw_s2  <= hw;
			hh_s2  <= hh;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 2 -> 3: sum, truncate toward zero, re-center, bounds check
	// ---------------------------------------------------------------------
	always_comb begin
		sx    = SUM_W'(pcx_s2) - SUM_W'(psy_s2);
		sy    = SUM_W'(psx_s2) + SUM_W'(pcy_s2);
		// bias negative sums so the arithmetic shift rounds toward zero
		rnd_x = sx[SUM_W-1] ? $signed(SUM_W'((1 << FRAC_W) - 1)) : '0;
		rnd_y = sy[SUM_W-1] ? $signed(SUM_W'((1 << FRAC_W) - 1)) : '0;
		sxa   = sx + rnd_x;
		sya   = sy + rnd_y;
		tqx   = sxa[SUM_W-1:FRAC_W];
		tqy   = sya[SUM_W-1:FRAC_W];
		rx    = $signed({tqx[TQ_W-1], tqx}) + $signed(RX_W'(hw_s2));
		ry    = $signed({tqy[TQ_W-1], tqy}) + $signed(RX_W'(hh_s2));
		in_x  = !rx[RX_W-1] && (rx < $signed(RX_W'(w_s2)));
		in_y  = !ry[RX_W-1] && (ry < $signed(RX_W'(h_s2)));
		in_img = in_x && in_y;
	end

	// Single store port: loads write, queries read, one of them per cycle
	assign load_ok = (32'(x_s2) < MAX_DIM) && (32'(y_s2) < MAX_DIM);
	assign mem_wr  = v_s2 && op_s2 == OP_LOAD && load_ok;
	assign rd_en   = v_s2 && op_s2 == OP_QUERY && s3_free;
	assign mem_addr = (op_s2 == OP_LOAD) ? {AW'(y_s2), AW'(x_s2)}
	                                     : {ry[AW-1:0], rx[AW-1:0]};

	always_ff @(posedge clk) begin
		if (mem_wr) begin
			mem[mem_addr] <= pix_s2;
		end
		if (rd_en) begin
			rd_s3 <= mem[mem_addr];
		end
	end

	// ---------------------------------------------------------------------
	// Stage 3: result register
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (s3_free) begin
			v_s3 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			inside_s3 <= in_img;
		end
	end

	assign result.valid      = v_s3;
	assign result.inside_res = inside_s3;
	assign result.pixel_out  = inside_s3 ? rd_s3 : '0;

	// ---------------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------------
	a_one_port_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_wr && rd_en))
		else $error("store written and read in the same cycle");

	a_read_lands: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |=> v_s3)
		else $error("query read did not reach the result register");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !result.ready) |-> !rd_en)
		else $error("stalled result overwritten by a new read");

	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!item.ready |-> (v_s1 && v_s2))
		else $error("input stalled while a stage is empty");

endmodule

`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the inverse-map image rotator.
// Loads fill a shadow copy of the source store; every query is rotated back
// here with the same Q2.14 arithmetic and truncation toward zero. The result
// is queued and compared against the block's result transactions in order.
// A query that would sample an entry never loaded is preceded by a load of
// that entry, so no query result ever shows undefined store contents.
module tb;
	import irim_pkg::*;

	localparam int MAX_DIM     = 128;
	localparam int CYCLE_LIMIT = 300000;
	// Up to three stages can be in flight.
	localparam int SETTLE_CYCLES = 6;

	typedef struct packed {
		logic             in_img;
		logic [PIX_W-1:0] pixel;
	} rot_sample_t;

	logic clk = 1'b0;
	logic arst_n;

	irim_in_if  item_if ();
	irim_out_if res_if ();
	irim_cfg_if cfg_if ();

	image_rotate_inverse_map #(
		.MAX_DIM (MAX_DIM)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_if),
		.result (res_if),
		.cfg    (cfg_if)
	);

	// Shadow of the block: source store plus register file.
	logic [PIX_W-1:0]        src_pix [MAX_DIM*MAX_DIM];
	bit                      src_written [MAX_DIM*MAX_DIM];
	logic signed [COEF_W-1:0] cos_m;
	logic signed [COEF_W-1:0] sin_m;
	logic [DIM_W-1:0]        wid_m;
	logic [DIM_W-1:0]        hgt_m;

	rot_sample_t pending_samples [$];
	rot_sample_t got_sample;
	rot_sample_t want_sample;
	int          n_mismatch = 0;
	int          cycle_count = 0;
	bit          steady;   // when set, neither side idles

	always #4 clk = ~clk;

	// Truncate a Q14 value toward zero, as an integer cast would.
	function automatic longint q14_toward_zero(input longint v);
		if (v < 0) begin
			return -((-v) >>> FRAC_W);
		end
		return v >>> FRAC_W;
	endfunction

	// Map a destination pixel back into the source image.
	function automatic void rotate_back(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
			output bit hit, output int sx, output int sy);
		int w, h, hw, hh, dx, dy;
		longint c, s;
		w  = (wid_m > MAX_DIM) ? MAX_DIM : int'(wid_m);
		h  = (hgt_m > MAX_DIM) ? MAX_DIM : int'(hgt_m);
		hw = w / 2;
		hh = h / 2;
		dx = int'(x) - hw;
		dy = int'(y) - hh;
		c  = cos_m;
		s  = sin_m;
		sx = int'(q14_toward_zero(dx * c - dy * s)) + hw;
		sy = int'(q14_toward_zero(dx * s + dy * c)) + hh;
		hit = (sx >= 0) && (sx < w) && (sy >= 0) && (sy < h);
	endfunction

	// Drive one item and hold it until the block takes it; then update the
	// shadow store for a load, or queue the expected sample for a query.
	task automatic send_item(input op_t op, input logic [POS_W-1:0] x,
			input logic [POS_W-1:0] y, input logic [PIX_W-1:0] pix);
		bit hit;
		int sx, sy;
		rot_sample_t want;
		if (!steady && $urandom_range(99) < 30) begin
			item_if.valid <= 1'b0;
			repeat ($urandom_range(2, 1)) @(posedge clk);
		end
		item_if.valid    <= 1'b1;
		item_if.op       <= op;
		item_if.pos_x    <= x;
		item_if.pos_y    <= y;
		item_if.pixel_in <= pix;
		do @(posedge clk); while (!item_if.ready);
		if (op == OP_LOAD) begin
			src_pix[y*MAX_DIM + x]     = pix;
			src_written[y*MAX_DIM + x] = 1'b1;
		end else begin
			rotate_back(x, y, hit, sx, sy);
			want.in_img = hit;
			want.pixel  = hit ? src_pix[sy*MAX_DIM + sx] : '0;
			pending_samples.push_back(want);
		end
	endtask

	// Query one destination pixel; load the sampled entry first if it is fresh.
	task automatic query_pixel(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y);
		bit hit;
		int sx, sy;
		rotate_back(x, y, hit, sx, sy);
		if (hit && !src_written[sy*MAX_DIM + sx]) begin
			send_item(OP_LOAD, POS_W'(sx), POS_W'(sy), $urandom);
		end
		send_item(OP_QUERY, x, y, $urandom);
	endtask

	// Drop valid, wait out every expected result, then let loads drain.
	task automatic settle_block();
		item_if.valid <= 1'b0;
		do @(posedge clk); while (pending_samples.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= val;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		case (idx)
			REG_COS:    cos_m = val;
			REG_SIN:    sin_m = val;
			REG_WIDTH:  wid_m = val[DIM_W-1:0];
			REG_HEIGHT: hgt_m = val[DIM_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Reprogram angle and size, only once the block is idle.
	task automatic set_geometry(input logic [COEF_W-1:0] c, input logic [COEF_W-1:0] s,
			input logic [CFG_DATA_W-1:0] wd, input logic [CFG_DATA_W-1:0] hd);
		settle_block();
		write_reg(REG_COS, c);
		write_reg(REG_SIN, s);
		write_reg(REG_WIDTH, wd);
		write_reg(REG_HEIGHT, hd);
	endtask

	// Reset values give the identity map: every pixel samples itself.
	task automatic test_reset_identity();
		send_item(OP_LOAD, 7'd0, 7'd0, 32'h0000_0000);
		send_item(OP_LOAD, 7'd127, 7'd127, 32'hFFFF_FFFF);
		send_item(OP_LOAD, 7'd127, 7'd0, 32'hAAAA_AAAA);
		send_item(OP_LOAD, 7'd0, 7'd127, 32'h5555_5555);
		query_pixel(7'd0, 7'd0);
		query_pixel(7'd127, 7'd127);
		query_pixel(7'd127, 7'd0);
		query_pixel(7'd0, 7'd127);
		query_pixel(7'd64, 7'd64);
	endtask

	task automatic test_special_geometry();
		// quarter turn at full size
		set_geometry(16'sd0, 16'sd16384, 16'd128, 16'd128);
		query_pixel(7'd0, 7'd0);
		query_pixel(7'd10, 7'd20);
		// half turn on an odd-sized image, plus a query beyond the image
		set_geometry(-16'sd16384, 16'sd0, 16'd7, 16'd5);
		query_pixel(7'd0, 7'd0);
		query_pixel(7'd6, 7'd4);
		query_pixel(7'd127, 7'd127);
		// zero width: everything falls outside
		set_geometry(16'sd16384, 16'sd0, 16'd0, 16'd128);
		query_pixel(7'd0, 7'd0);
		query_pixel(7'd5, 7'd5);
		// oversized dimensions clamp to the store size; upper data byte ignored
		set_geometry(16'sd16384, 16'sd0, 16'h00FF, 16'hABC8);
		query_pixel(7'd127, 7'd127);
		query_pixel(7'd0, 7'd0);
		// angle registers at the ends of their 16-bit range
		set_geometry(16'h8000, 16'h7FFF, 16'd128, 16'd128);
		query_pixel(7'd64, 7'd64);
		query_pixel(7'd0, 7'd127);
		query_pixel(7'd127, 7'd0);
		// single-pixel image
		set_geometry(16'sd16384, 16'sd0, 16'd1, 16'd1);
		query_pixel(7'd0, 7'd0);
		query_pixel(7'd1, 7'd0);
	endtask

	// One phase: pick a geometry, then a stream of mostly queries with
	// some stray loads mixed in.
	task automatic run_rotation_phase(input int n_items);
		logic [COEF_W-1:0] c, s;
		logic [CFG_DATA_W-1:0] wd, hd;
		logic [POS_W-1:0] x, y;
		int w_eff, h_eff;
		case ($urandom_range(3))
			0, 3: begin
				// exact angles from a short table, random quadrant
				case ($urandom_range(5))
					0: begin c = 16'sd16384; s = 16'sd0;     end
					1: begin c = 16'sd0;     s = 16'sd16384; end
					2: begin c = 16'sd11585; s = 16'sd11585; end
					3: begin c = 16'sd14189; s = 16'sd8192;  end
					4: begin c = 16'sd8192;  s = 16'sd14189; end
					default: begin c = 16'sd15137; s = 16'sd6270; end
				endcase
				if ($urandom_range(1)) c = -c;
				if ($urandom_range(1)) s = -s;
			end
			1: begin
				c = COEF_W'($urandom_range(32768) - 16384);
				s = COEF_W'($urandom_range(32768) - 16384);
			end
			default: begin
				c = COEF_W'($urandom);
				s = COEF_W'($urandom);
			end
		endcase
		// sizes: mostly in range, sometimes zero or oversized
		case ($urandom_range(15))
			0:       wd[7:0] = 8'd0;
			1, 2:    wd[7:0] = 8'd128;
			3:       wd[7:0] = 8'($urandom_range(255, 129));
			default: wd[7:0] = 8'($urandom_range(128, 1));
		endcase
		case ($urandom_range(15))
			0:       hd[7:0] = 8'd0;
			1, 2:    hd[7:0] = 8'd128;
			3:       hd[7:0] = 8'($urandom_range(255, 129));
			default: hd[7:0] = 8'($urandom_range(128, 1));
		endcase
		wd[15:8] = 8'($urandom);
		hd[15:8] = 8'($urandom);
		set_geometry(c, s, wd, hd);
		w_eff = (wid_m > MAX_DIM) ? MAX_DIM : int'(wid_m);
		h_eff = (hgt_m > MAX_DIM) ? MAX_DIM : int'(hgt_m);
		repeat (n_items) begin
			if ($urandom_range(99) < 15) begin
				send_item(OP_LOAD, POS_W'($urandom), POS_W'($urandom), $urandom);
			end else begin
				// keep most queries inside the destination image
				x = (w_eff > 0 && $urandom_range(99) < 80) ?
					POS_W'($urandom_range(w_eff - 1)) : POS_W'($urandom);
				y = (h_eff > 0 && $urandom_range(99) < 80) ?
					POS_W'($urandom_range(h_eff - 1)) : POS_W'($urandom);
				query_pixel(x, y);
			end
		end
		settle_block();
	endtask

	task automatic test_random_rotations();
		repeat (5) run_rotation_phase(55);
	endtask

	// Full-rate stretch: no gaps on the sender, no stalls on the receiver.
	task automatic test_back_to_back();
		steady = 1'b1;
		run_rotation_phase(100);
		steady = 1'b0;
	endtask

	// Receiver backpressure, about a third of the cycles.
	always @(posedge clk) begin
		res_if.ready <= steady || ($urandom_range(99) >= 33);
	end

	// Compare each result transaction with the oldest expected sample.
	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready) begin
			got_sample.in_img = res_if.inside_res;
			got_sample.pixel  = res_if.pixel_out;
			if (pending_samples.size() == 0) begin
				$display("%0t: unexpected result, actual inside=%0b pixel=%h",
					$time, got_sample.in_img, got_sample.pixel);
				n_mismatch++;
			end else begin
				want_sample = pending_samples.pop_front();
				if (got_sample.in_img !== want_sample.in_img) begin
					$display("%0t: inside_res mismatch, expected %0b actual %0b",
						$time, want_sample.in_img, got_sample.in_img);
					n_mismatch++;
				end
				if (got_sample.pixel !== want_sample.pixel) begin
					$display("%0t: pixel_out mismatch, expected %h actual %h",
						$time, want_sample.pixel, got_sample.pixel);
					n_mismatch++;
				end
			end
		end
	end

	// Hard stop if the block hangs.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		steady      = 1'b0;
		cos_m       = COS_RST;
		sin_m       = SIN_RST;
		wid_m       = WIDTH_RST;
		hgt_m       = HEIGHT_RST;
		// Hold every input at a known value through reset.
		arst_n           <= 1'b0;
		item_if.valid    <= 1'b0;
		item_if.op       <= OP_LOAD;
		item_if.pos_x    <= '0;
		item_if.pos_y    <= '0;
		item_if.pixel_in <= '0;
		cfg_if.valid     <= 1'b0;
		cfg_if.index     <= REG_COS;
		cfg_if.data      <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_identity();
		test_special_geometry();
		test_random_rotations();
		test_back_to_back();
		settle_block();

		if (n_mismatch == 0 && pending_samples.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
